FILE: src/opsc_pkg.sv
// Package for the odd-only prime sieve counter: FSM state type, widths, root table.
package opsc_pkg;

  localparam int unsigned POWER_W = 5;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned ROOT_W  = 13;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MARK,
    S_SEEK,
    S_SEEK_CHK,
    S_TEST,
    S_COUNT,
    S_DONE
  } opsc_state_t;

  // floor(sqrt(2^p)) for p = 1..24
  function automatic logic [ROOT_W-1:0] root_of_pow2(input logic [POWER_W-1:0] p);
    logic [ROOT_W-1:0] r;
    case (p)
      5'd1:    r = 13'd1;
      5'd2:    r = 13'd2;
      5'd3:    r = 13'd2;
      5'd4:    r = 13'd4;
      5'd5:    r = 13'd5;
      5'd6:    r = 13'd8;
      5'd7:    r = 13'd11;
      5'd8:    r = 13'd16;
      5'd9:    r = 13'd22;
      5'd10:   r = 13'd32;
      5'd11:   r = 13'd45;
      5'd12:   r = 13'd64;
      5'd13:   r = 13'd90;
      5'd14:   r = 13'd128;
      5'd15:   r = 13'd181;
      5'd16:   r = 13'd256;
      5'd17:   r = 13'd362;
      5'd18:   r = 13'd512;
      5'd19:   r = 13'd724;
      5'd20:   r = 13'd1024;
      5'd21:   r = 13'd1448;
      5'd22:   r = 13'd2048;
      5'd23:   r = 13'd2896;
      5'd24:   r = 13'd4096;
      default: r = 13'd1;
    endcase
    return r;
  endfunction

endpackage

FILE: src/opsc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module opsc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/odd_only_prime_sieve_counter.sv
// Odd-only sieve of Eratosthenes: counts the primes up to 2^p for each input word.
//
// Each input word carries p (0 reads as 1, above MAX_POWER saturates); the result word
// is the number of primes <= 2^p including 2, modulo 2^13. One flag per odd value
// 3..N-1 lives in a single-bit RAM of 2^(MAX_POWER-1) entries. The sieve marks one
// flag per cycle, scans for the next unmarked value with a read in S_SEEK and a test in
// S_SEEK_CHK for each index, and then counts the flags at one per cycle while writing
// them back clear, so the store is clean for the next word. All steps share the single
// RAM write/read port. After reset a clearing pass over all 2^(MAX_POWER-1) entries
// runs before the first input word is taken.
// One word is worked on at a time; the next is taken while a result waits on the output.
module odd_only_prime_sieve_counter
  import opsc_pkg::*;
#(
  parameter int unsigned MAX_POWER = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [POWER_W-1:0] in_limit_power,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] out_prime_count
);

  localparam int unsigned DEPTH = 2 ** (MAX_POWER - 1);
  localparam int unsigned IW    = MAX_POWER - 1;
  localparam int unsigned OW    = MAX_POWER - 1;
  localparam int unsigned XW    = MAX_POWER;
  localparam int unsigned CW    = MAX_POWER + 1;
  localparam int unsigned PW    = CW + 1;

  opsc_state_t        state_r, state_nxt;
  logic [OW-1:0]      odd_r, odd_nxt;
  logic [ROOT_W-1:0]  lim_r, lim_nxt;
  logic [CW-1:0]      c_r, c_nxt;
  logic [PW-1:0]      i_r, i_nxt;
  logic [XW-1:0]      idx_r, idx_nxt;
  logic [XW-1:0]      k_r, k_nxt;
  logic               rd_v_r, rd_v_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [0:0]         ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [0:0]         ram_rdata;

  logic [POWER_W-1:0] p_sat;
  logic [CW-1:0]      odd_full;
  logic [XW-1:0]      seek_idx;
  logic [CW-1:0]      c_sub;

  opsc_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_flags (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (in_limit_power == '0) begin
      p_sat = POWER_W'(1);
    end else if (in_limit_power > POWER_W'(MAX_POWER)) begin
      p_sat = POWER_W'(MAX_POWER);
    end else begin
      p_sat = in_limit_power;
    end
    odd_full = (CW'(1) << (p_sat - POWER_W'(1))) - CW'(1);
  end

  assign seek_idx = idx_r + XW'(1);
  assign c_sub    = c_r - CW'(3);

  always_comb begin
    state_nxt     = state_r;
    odd_nxt       = odd_r;
    lim_nxt       = lim_r;
    c_nxt         = c_r;
    i_nxt         = i_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    rd_v_nxt      = 1'b0;
    cnt_nxt       = cnt_r + COUNT_W'(rd_v_r && !ram_rdata[0]);
    out_valid_nxt = out_valid_r && out_stall;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = i_r[IW-1:0];
    ram_wdata     = 1'b1;
    ram_raddr     = seek_idx[IW-1:0];
    in_stall      = 1'b1;

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IW-1:0];
        ram_wdata = 1'b0;
        k_nxt     = k_r + XW'(1);
        if (k_r == XW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          odd_nxt   = odd_full[OW-1:0];
          lim_nxt   = root_of_pow2(p_sat);
          c_nxt     = CW'(3);
          i_nxt     = PW'(3);
          idx_nxt   = '0;
          cnt_nxt   = COUNT_W'(1);
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (i_r < PW'(odd_r)) begin
          ram_we = 1'b1;
          i_nxt  = i_r + PW'(c_r);
        end else begin
          state_nxt = S_SEEK;
        end
      end
      S_SEEK: begin
        idx_nxt = seek_idx;
        if (seek_idx >= XW'(odd_r)) begin
          c_nxt     = CW'(3) + {seek_idx, 1'b0};
          state_nxt = S_TEST;
        end else begin
          state_nxt = S_SEEK_CHK;
        end
      end
      S_SEEK_CHK: begin
        if (ram_rdata[0]) begin
          state_nxt = S_SEEK;
        end else begin
          c_nxt     = CW'(3) + {idx_r, 1'b0};
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (c_r <= CW'(lim_r)) begin
          i_nxt     = PW'(c_r) + PW'(c_sub >> 1);
          state_nxt = S_MARK;
        end else begin
          k_nxt     = '0;
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        ram_raddr = k_r[IW-1:0];
        ram_waddr = k_r[IW-1:0];
        ram_wdata = 1'b0;
        if (k_r < XW'(odd_r)) begin
          ram_we   = 1'b1;
          rd_v_nxt = 1'b1;
          k_nxt    = k_r + XW'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
        k_nxt     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odd_r     <= odd_nxt;
    lim_r     <= lim_nxt;
    c_r       <= c_nxt;
    i_r       <= i_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_prime_count = out_cnt_r;

`ifndef ASSERT_OFF
  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK && ram_we) |-> (i_r < PW'(odd_r)))
    else $error("mark write beyond the odd values in use");

  a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST) |-> c_r[0])
    else $error("sieving value is even");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside the done state");

  a_count_read_only_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == S_COUNT || state_r == S_DONE))
    else $error("count read pending outside the count pass");
`endif

endmodule

FILE: tb/sv/odd_only_prime_sieve_counter_chk.sv
// Checker for the prime sieve counter: predicts each count and compares the result words.
module odd_only_prime_sieve_counter_chk
  import opsc_pkg::*;
#(
  parameter int unsigned MAX_POWER = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [POWER_W-1:0] in_limit_power,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [COUNT_W-1:0] out_prime_count,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FLAG_DEPTH = 1 << (MAX_POWER - 1);

  logic [COUNT_W-1:0] expected_counts[$];
  bit                 sieve_flags[FLAG_DEPTH];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [COUNT_W-1:0] count_primes(input logic [POWER_W-1:0] pw);
    longint unsigned p, n, odd, idx, i, cand, clear;
    p = pw;
    if (p < 1) p = 1;
    if (p > MAX_POWER) p = MAX_POWER;
    n   = longint'(1) << p;
    odd = n / 2 - 1;
    for (i = 0; i < FLAG_DEPTH; i++) sieve_flags[i] = 1'b0;
    cand = 3;
    idx  = 0;
    do begin
      for (i = cand + (cand - 3) / 2; i < odd; i += cand) sieve_flags[i] = 1'b1;
      // next unmarked odd value, bounded to the store
      do idx++; while (idx < odd && sieve_flags[idx]);
      cand = 3 + 2 * idx;
    end while (cand * cand <= n);
    clear = 1;
    for (i = 0; i < odd; i++)
      if (!sieve_flags[i]) clear++;
    return clear[COUNT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [COUNT_W-1:0] want;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_counts.push_back(count_primes(in_limit_power));
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("unexpected result word", -1, out_prime_count);
        end else begin
          want = expected_counts.pop_front();
          if (out_prime_count !== want) report_mismatch("prime_count", want, out_prime_count);
        end
      end
      pending = expected_counts.size();
    end
  end

endmodule

FILE: tb/sv/odd_only_prime_sieve_counter_tb.sv
// Testbench top for the prime sieve counter: clock, reset, stimulus and verdict.
module odd_only_prime_sieve_counter_tb
  import opsc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_POWER   = 16;
  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int unsigned N_RANDOM    = 80;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [POWER_W-1:0] in_limit_power = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COUNT_W-1:0] out_prime_count;

  int  fail_count;
  int  pending;
  int  cycles = 0;
  bit  idle_on = 1'b1;

  logic [POWER_W-1:0] directed_powers[$] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
    5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd31, 5'd1, 5'd0, 5'd2
  };

  odd_only_prime_sieve_counter #(.MAX_POWER(MAX_POWER)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_limit_power (in_limit_power),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_prime_count(out_prime_count)
  );

  odd_only_prime_sieve_counter_chk #(.MAX_POWER(MAX_POWER)) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_limit_power (in_limit_power),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_prime_count(out_prime_count),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 22);
  end

  task automatic send_word(input logic [POWER_W-1:0] p);
    while (idle_on && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_limit_power <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    logic [POWER_W-1:0] p;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_powers[k]) send_word(directed_powers[k]);
    for (int k = 0; k < N_RANDOM; k++) begin
      idle_on = !(k >= 40 && k < 70);
      // mostly small sieves; a few mid-sized ones
      if ($urandom_range(0, 24) == 0) p = POWER_W'($urandom_range(11, 13));
      else p = POWER_W'($urandom_range(0, 10));
      send_word(p);
    end
    idle_on = 1'b1;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
